>>> rtl/core/cpid_pkg.sv
`timescale 1ns / 1ps

package cpid_pkg;

  // fixed field widths
  localparam int unsigned IN_BITS      = 32;
  localparam int unsigned OUT_BITS     = 48;
  localparam int unsigned GAIN_BITS    = 24;
  localparam int unsigned LIMIT_BITS   = 47;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned NUM_GAINS    = 6;

  // default parameter values
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned DATA_WIDTH_DEF = 48;

  // multiplier partial product slice of the data operand
  localparam int unsigned MUL_CHUNK = 16;

  // register map
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTER_KP  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTER_KI  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTER_KD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER_KP  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER_KI  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER_KD  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIM_INT   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIM_OUT   = 3'd7;

  // reset values
  localparam logic [GAIN_BITS-1:0] OUTER_KP_RST = 24'd65536;
  localparam logic [GAIN_BITS-1:0] OUTER_KI_RST = 24'd0;
  localparam logic [GAIN_BITS-1:0] OUTER_KD_RST = 24'd196608;
  localparam logic [GAIN_BITS-1:0] INNER_KP_RST = 24'd65536;
  localparam logic [GAIN_BITS-1:0] INNER_KI_RST = 24'd0;
  localparam logic [GAIN_BITS-1:0] INNER_KD_RST = 24'd327680;
  // limits in whole units, shifted up by the fraction width at elaboration
  localparam logic [LIMIT_BITS-1:0] LIM_INT_UNITS = 47'd500;
  localparam logic [LIMIT_BITS-1:0] LIM_OUT_UNITS = 47'd65535;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_MUL_D,
    ST_MUL_P,
    ST_MUL_I,
    ST_ACC,
    ST_ACC_CLAMP,
    ST_SUM_PD,
    ST_SUM_ACC,
    ST_OUT_CLAMP
  } cpid_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_ACC,
    MUL_NEG,
    MUL_SAT
  } cpid_mul_state_e;

  // multiplier handshake back to the sequencer
  typedef struct packed {
    logic done;
    logic busy;
  } cpid_mul_status_t;

endpackage

>>> rtl/core/cpid_mul.sv
`timescale 1ns / 1ps

// Sequential signed a*g >>> FRAC_BITS, saturated to DATA_WIDTH.
// Magnitudes are multiplied one 16-bit slice of a per cycle, MSB first.
module cpid_mul #(
  parameter int unsigned DATA_WIDTH = cpid_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cpid_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [DATA_WIDTH-1:0]          a_i,
  input  logic signed [cpid_pkg::GAIN_BITS-1:0] g_i,
  output cpid_pkg::cpid_mul_status_t            status_o,
  output logic signed [DATA_WIDTH-1:0]          p_o
);

  localparam int unsigned CW   = cpid_pkg::MUL_CHUNK;
  localparam int unsigned GW   = cpid_pkg::GAIN_BITS;
  localparam int unsigned NCH  = (DATA_WIDTH + CW - 1) / CW;
  localparam int unsigned AW   = NCH * CW;
  localparam int unsigned PW   = DATA_WIDTH + GW;
  localparam int unsigned CNTW = $clog2(NCH);

  localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  cpid_pkg::cpid_mul_state_e state_q, state_d;
  logic [AW-1:0]         a_q, a_d;
  logic [GW-1:0]         g_q, g_d;
  logic                  neg_q, neg_d;
  logic [PW-1:0]         acc_q, acc_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] p_q, p_d;
  logic                  done_q, done_d;

  logic [DATA_WIDTH-1:0] a_mag;
  logic [GW-1:0]         g_mag;
  logic [CW+GW-1:0]      pp;
  logic [PW-1:0]         sh;
  logic [PW-DATA_WIDTH:0] hi;

  assign a_mag = a_i[DATA_WIDTH-1] ? (~a_i + DATA_WIDTH'(1)) : a_i;
  assign g_mag = g_i[GW-1] ? (~g_i + GW'(1)) : g_i;
  assign pp    = a_q[AW-1 -: CW] * g_q;
  assign sh    = PW'($signed(acc_q) >>> FRAC_BITS);
  assign hi    = sh[PW-1:DATA_WIDTH-1];

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    g_d     = g_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    done_d  = 1'b0;
    case (state_q)
      cpid_pkg::MUL_IDLE: begin
        if (start_i) begin
          a_d     = AW'(a_mag);
          g_d     = g_mag;
          neg_d   = a_i[DATA_WIDTH-1] ^ g_i[GW-1];
          acc_d   = '0;
          cnt_d   = '0;
          state_d = cpid_pkg::MUL_ACC;
        end
      end
      cpid_pkg::MUL_ACC: begin
        acc_d = (acc_q << CW) + PW'(pp);
        a_d   = a_q << CW;
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(NCH - 1)) begin
          state_d = cpid_pkg::MUL_NEG;
        end
      end
      cpid_pkg::MUL_NEG: begin
        acc_d   = neg_q ? (~acc_q + PW'(1)) : acc_q;
        state_d = cpid_pkg::MUL_SAT;
      end
      cpid_pkg::MUL_SAT: begin
        // in range when the result sign and all bits above it agree
        if ((&hi) || (~|hi)) begin
          p_d = sh[DATA_WIDTH-1:0];
        end else begin
          p_d = sh[PW-1] ? DMIN : DMAX;
        end
        done_d  = 1'b1;
        state_d = cpid_pkg::MUL_IDLE;
      end
      default: begin
        state_d = cpid_pkg::MUL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpid_pkg::MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    g_q   <= g_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    p_q   <= p_d;
  end

  assign status_o.done = done_q;
  assign status_o.busy = (state_q != cpid_pkg::MUL_IDLE);
  assign p_o           = p_q;

endmodule

>>> rtl/core/cascade_pid_controller_core.sv
`timescale 1ns / 1ps
// The sequencer handles one item at a time: a new input beat is taken only in idle, once
//   the previous item's drive beat has been loaded into the output register.
// Each item runs both loops through the shared 16x24-slice multiplier (six products per
//   item) and one add/sub unit.
// Reset (async, active low): gains and limits return to defaults, both loops' previous
//   error and integral clear to zero, the sequencer idles with no output pending.

module cascade_pid_controller_core #(
  parameter int unsigned FRAC_BITS  = cpid_pkg::FRAC_BITS_DEF,
  parameter int unsigned DATA_WIDTH = cpid_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [31:0] setpoint, [63:32] outer_measure, [95:64] inner_measure
  input  logic [3*cpid_pkg::IN_BITS-1:0]        s_axis_tdata,
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [47:0] drive, [95:48] outer_command
  output logic [2*cpid_pkg::OUT_BITS-1:0]       m_axis_tdata,
  // register write port
  input  logic                                  cfg_we_i,
  input  logic [cpid_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [cpid_pkg::LIMIT_BITS-1:0]       cfg_wdata_i
);

  localparam int unsigned IW  = cpid_pkg::IN_BITS;
  localparam int unsigned OW  = cpid_pkg::OUT_BITS;
  localparam int unsigned GW  = cpid_pkg::GAIN_BITS;
  localparam int unsigned LW  = cpid_pkg::LIMIT_BITS;
  localparam int unsigned EXT = (LW > DATA_WIDTH) ? LW : DATA_WIDTH;

  localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  localparam logic [LW-1:0] LIM_INT_RST = cpid_pkg::LIM_INT_UNITS << FRAC_BITS;
  localparam logic [LW-1:0] LIM_OUT_RST = cpid_pkg::LIM_OUT_UNITS << FRAC_BITS;

  // A limit beyond the data range acts as the largest data value.
  function automatic logic [DATA_WIDTH-1:0] clip_lim(input logic [LW-1:0] raw);
    logic [EXT-1:0] r;
    logic [EXT-1:0] m;
    r = EXT'(raw);
    m = EXT'(DMAX);
    return (r > m) ? DMAX : r[DATA_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: gains raw, limits stored pre-clipped with their negatives so
  // the clamp step is two compares only.
  // ---------------------------------------------------------------------------
  logic [GW-1:0]                gain_q [cpid_pkg::NUM_GAINS];
  logic signed [DATA_WIDTH-1:0] lim_int_q, lim_int_n_q;
  logic signed [DATA_WIDTH-1:0] lim_out_q, lim_out_n_q;
  logic [DATA_WIDTH-1:0]        cfg_lim;

  assign cfg_lim = clip_lim(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[cpid_pkg::REG_OUTER_KP] <= cpid_pkg::OUTER_KP_RST;
      gain_q[cpid_pkg::REG_OUTER_KI] <= cpid_pkg::OUTER_KI_RST;
      gain_q[cpid_pkg::REG_OUTER_KD] <= cpid_pkg::OUTER_KD_RST;
      gain_q[cpid_pkg::REG_INNER_KP] <= cpid_pkg::INNER_KP_RST;
      gain_q[cpid_pkg::REG_INNER_KI] <= cpid_pkg::INNER_KI_RST;
      gain_q[cpid_pkg::REG_INNER_KD] <= cpid_pkg::INNER_KD_RST;
      lim_int_q   <= clip_lim(LIM_INT_RST);
      lim_int_n_q <= -clip_lim(LIM_INT_RST);
      lim_out_q   <= clip_lim(LIM_OUT_RST);
      lim_out_n_q <= -clip_lim(LIM_OUT_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpid_pkg::REG_OUTER_KP, cpid_pkg::REG_OUTER_KI, cpid_pkg::REG_OUTER_KD,
        cpid_pkg::REG_INNER_KP, cpid_pkg::REG_INNER_KI, cpid_pkg::REG_INNER_KD: begin
          gain_q[cfg_index_i] <= cfg_wdata_i[GW-1:0];
        end
        cpid_pkg::REG_LIM_INT: begin
          lim_int_q   <= cfg_lim;
          lim_int_n_q <= -cfg_lim;
        end
        cpid_pkg::REG_LIM_OUT: begin
          lim_out_q   <= cfg_lim;
          lim_out_n_q <= -cfg_lim;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers. loop_q selects outer (0) or
  // inner (1); both loops run through the same step sequence.
  // ---------------------------------------------------------------------------
  cpid_pkg::cpid_state_e state_q, state_d;
  logic                  loop_q, loop_d;
  logic                  issued_q, issued_d;     // product request already sent
  logic                  out_valid_q, out_valid_d;

  logic [IW-1:0]                sp_q, sp_d;
  logic [IW-1:0]                om_q, om_d;
  logic [IW-1:0]                im_q, im_d;
  logic signed [DATA_WIDTH-1:0] err_q, err_d;
  logic signed [DATA_WIDTH-1:0] tmp_q, tmp_d;    // diff, integral term, sums
  logic signed [DATA_WIDTH-1:0] pterm_q, pterm_d;
  logic signed [DATA_WIDTH-1:0] dterm_q, dterm_d;
  logic signed [DATA_WIDTH-1:0] cmd_q, cmd_d;
  logic signed [DATA_WIDTH-1:0] prev_q [2];
  logic signed [DATA_WIDTH-1:0] prev_d [2];
  logic signed [DATA_WIDTH-1:0] accum_q [2];
  logic signed [DATA_WIDTH-1:0] accum_d [2];
  logic [OW-1:0]                drive_q, drive_d;
  logic [OW-1:0]                ocmd_q, ocmd_d;

  // shared saturating add/sub
  logic signed [DATA_WIDTH-1:0] alu_a, alu_b, alu_r;
  logic                         alu_sub;
  logic signed [DATA_WIDTH:0]   alu_s;

  // shared symmetric clamp on tmp_q
  logic signed [DATA_WIDTH-1:0] clamp_lim, clamp_lim_n, clamp_r;

  // multiplier
  logic                               mul_start;
  logic signed [DATA_WIDTH-1:0]       mul_a;
  logic [cpid_pkg::CFG_IDX_BITS-1:0]  gidx;
  cpid_pkg::cpid_mul_status_t         mul_st;
  logic signed [DATA_WIDTH-1:0]       mul_p;

  // operand select for the add/sub unit
  always_comb begin
    alu_a   = err_q;
    alu_b   = tmp_q;
    alu_sub = 1'b0;
    case (state_q)
      cpid_pkg::ST_ERR: begin
        alu_a   = loop_q ? cmd_q : DATA_WIDTH'($signed(sp_q));
        alu_b   = loop_q ? DATA_WIDTH'($signed(im_q)) : DATA_WIDTH'($signed(om_q));
        alu_sub = 1'b1;
      end
      cpid_pkg::ST_DIFF: begin
        alu_a   = err_q;
        alu_b   = prev_q[loop_q];
        alu_sub = 1'b1;
      end
      cpid_pkg::ST_ACC: begin
        alu_a = accum_q[loop_q];
        alu_b = tmp_q;
      end
      cpid_pkg::ST_SUM_PD: begin
        alu_a = pterm_q;
        alu_b = dterm_q;
      end
      cpid_pkg::ST_SUM_ACC: begin
        alu_a = tmp_q;
        alu_b = accum_q[loop_q];
      end
      default: begin
      end
    endcase
  end

  // one extra bit holds the exact result; saturate when the top two disagree
  assign alu_s = alu_sub ? ({alu_a[DATA_WIDTH-1], alu_a} - {alu_b[DATA_WIDTH-1], alu_b})
                         : ({alu_a[DATA_WIDTH-1], alu_a} + {alu_b[DATA_WIDTH-1], alu_b});
  assign alu_r = (alu_s[DATA_WIDTH] != alu_s[DATA_WIDTH-1])
               ? (alu_s[DATA_WIDTH] ? DMIN : DMAX)
               : alu_s[DATA_WIDTH-1:0];

  assign clamp_lim   = (state_q == cpid_pkg::ST_ACC_CLAMP) ? lim_int_q : lim_out_q;
  assign clamp_lim_n = (state_q == cpid_pkg::ST_ACC_CLAMP) ? lim_int_n_q : lim_out_n_q;
  always_comb begin
    if (tmp_q > clamp_lim) begin
      clamp_r = clamp_lim;
    end else if (tmp_q < clamp_lim_n) begin
      clamp_r = clamp_lim_n;
    end else begin
      clamp_r = tmp_q;
    end
  end

  // gain select: derivative works on the error difference held in tmp_q
  always_comb begin
    case (state_q)
      cpid_pkg::ST_MUL_D: gidx = loop_q ? cpid_pkg::REG_INNER_KD : cpid_pkg::REG_OUTER_KD;
      cpid_pkg::ST_MUL_I: gidx = loop_q ? cpid_pkg::REG_INNER_KI : cpid_pkg::REG_OUTER_KI;
      default:            gidx = loop_q ? cpid_pkg::REG_INNER_KP : cpid_pkg::REG_OUTER_KP;
    endcase
  end
  assign mul_a = (state_q == cpid_pkg::ST_MUL_D) ? tmp_q : err_q;

  cpid_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .g_i      (gain_q[gidx]),
    .status_o (mul_st),
    .p_o      (mul_p)
  );

  // ---------------------------------------------------------------------------
  // Step sequence per loop:
  //   ERR       err = ref - fb
  //   DIFF      tmp = err - prev, prev = err
  //   MUL_D/P/I dterm = tmp*kd, pterm = err*kp, tmp = err*ki
  //   ACC       tmp = accum + tmp
  //   ACC_CLAMP accum = clamp(tmp, limit_integral)
  //   SUM_PD    tmp = pterm + dterm
  //   SUM_ACC   tmp = tmp + accum
  //   OUT_CLAMP clamp(tmp, limit_output) -> outer command, or drive beat
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    loop_d      = loop_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    sp_d        = sp_q;
    om_d        = om_q;
    im_d        = im_q;
    err_d       = err_q;
    tmp_d       = tmp_q;
    pterm_d     = pterm_q;
    dterm_d     = dterm_q;
    cmd_d       = cmd_q;
    prev_d      = prev_q;
    accum_d     = accum_q;
    drive_d     = drive_q;
    ocmd_d      = ocmd_q;
    mul_start   = 1'b0;
    case (state_q)
      cpid_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          sp_d    = s_axis_tdata[IW-1:0];
          om_d    = s_axis_tdata[2*IW-1:IW];
          im_d    = s_axis_tdata[3*IW-1:2*IW];
          loop_d  = 1'b0;
          state_d = cpid_pkg::ST_ERR;
        end
      end
      cpid_pkg::ST_ERR: begin
        err_d   = alu_r;
        state_d = cpid_pkg::ST_DIFF;
      end
      cpid_pkg::ST_DIFF: begin
        tmp_d          = alu_r;
        prev_d[loop_q] = err_q;
        state_d        = cpid_pkg::ST_MUL_D;
      end
      cpid_pkg::ST_MUL_D, cpid_pkg::ST_MUL_P, cpid_pkg::ST_MUL_I: begin
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_st.done) begin
          issued_d = 1'b0;
          case (state_q)
            cpid_pkg::ST_MUL_D: begin
              dterm_d = mul_p;
              state_d = cpid_pkg::ST_MUL_P;
            end
            cpid_pkg::ST_MUL_P: begin
              pterm_d = mul_p;
              state_d = cpid_pkg::ST_MUL_I;
            end
            default: begin
              tmp_d   = mul_p;
              state_d = cpid_pkg::ST_ACC;
            end
          endcase
        end
      end
      cpid_pkg::ST_ACC: begin
        tmp_d   = alu_r;
        state_d = cpid_pkg::ST_ACC_CLAMP;
      end
      cpid_pkg::ST_ACC_CLAMP: begin
        accum_d[loop_q] = clamp_r;
        state_d         = cpid_pkg::ST_SUM_PD;
      end
      cpid_pkg::ST_SUM_PD: begin
        tmp_d   = alu_r;
        state_d = cpid_pkg::ST_SUM_ACC;
      end
      cpid_pkg::ST_SUM_ACC: begin
        tmp_d   = alu_r;
        state_d = cpid_pkg::ST_OUT_CLAMP;
      end
      cpid_pkg::ST_OUT_CLAMP: begin
        if (!loop_q) begin
          // outer result becomes the inner reference
          cmd_d   = clamp_r;
          loop_d  = 1'b1;
          state_d = cpid_pkg::ST_ERR;
        end else if (!out_valid_q || m_axis_tready) begin
          // hold here while the previous beat is still unclaimed
          drive_d     = OW'(clamp_r);
          ocmd_d      = OW'(cmd_q);
          out_valid_d = 1'b1;
          loop_d      = 1'b0;
          state_d     = cpid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpid_pkg::ST_IDLE;
      loop_q      <= 1'b0;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      accum_q[0]  <= '0;
      accum_q[1]  <= '0;
    end else begin
      state_q     <= state_d;
      loop_q      <= loop_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      accum_q     <= accum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q    <= sp_d;
    om_q    <= om_d;
    im_q    <= im_d;
    err_q   <= err_d;
    tmp_q   <= tmp_d;
    pterm_q <= pterm_d;
    dterm_q <= dterm_d;
    cmd_q   <= cmd_d;
    drive_q <= drive_d;
    ocmd_q  <= ocmd_d;
  end

  assign s_axis_tready = (state_q == cpid_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ocmd_q, drive_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a product only comes back while a multiply step waits for it
  a_mul_done_in_mul_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> (issued_q && (state_q == cpid_pkg::ST_MUL_D ||
                                  state_q == cpid_pkg::ST_MUL_P ||
                                  state_q == cpid_pkg::ST_MUL_I)))
    else $error("product returned outside a multiply step");

  // no request while the multiplier is still working
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy)
    else $error("multiply issued while busy");

  // an output beat appears only after the inner loop output clamp
  a_out_from_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == cpid_pkg::ST_OUT_CLAMP && loop_q))
    else $error("output beat without inner loop completion");

  // the sequencer always restarts on the outer loop
  a_idle_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpid_pkg::ST_IDLE) |-> !loop_q)
    else $error("idle with inner loop selected");

endmodule

>>> dv/cascade_pid_controller_core_tb.sv
`timescale 1ns / 1ps

module cascade_pid_controller_core_tb;

  localparam int unsigned FRAC         = cpid_pkg::FRAC_BITS_DEF;
  localparam int unsigned DW           = cpid_pkg::DATA_WIDTH_DEF;
  localparam int unsigned IN_BITS      = cpid_pkg::IN_BITS;
  localparam int unsigned OUT_BITS     = cpid_pkg::OUT_BITS;
  localparam int unsigned GAIN_BITS    = cpid_pkg::GAIN_BITS;
  localparam int unsigned LIMIT_BITS   = cpid_pkg::LIMIT_BITS;
  localparam int unsigned CFG_IDX_BITS = cpid_pkg::CFG_IDX_BITS;
  localparam int unsigned NUM_GAINS    = cpid_pkg::NUM_GAINS;

  typedef logic signed [DW-1:0] q_t;
  // room for a 48 x 24 bit product and any sum of two data words
  typedef logic signed [95:0]   wide_t;

  localparam wide_t Q_MAX = (wide_t'(1) <<< (DW - 1)) - 1;
  localparam wide_t Q_MIN = -Q_MAX - 1;

  // Q16.16 input corners
  localparam logic [IN_BITS-1:0] IN_MAX  = {1'b0, {(IN_BITS-1){1'b1}}};
  localparam logic [IN_BITS-1:0] IN_MIN  = {1'b1, {(IN_BITS-1){1'b0}}};
  localparam logic [IN_BITS-1:0] IN_ONE  = IN_BITS'(1) << FRAC;
  localparam logic [IN_BITS-1:0] IN_NLSB = '1;
  // Q8.16 gain corners
  localparam logic [GAIN_BITS-1:0] G_MAX = {1'b0, {(GAIN_BITS-1){1'b1}}};
  localparam logic [GAIN_BITS-1:0] G_MIN = {1'b1, {(GAIN_BITS-1){1'b0}}};
  localparam logic [GAIN_BITS-1:0] G_ONE = GAIN_BITS'(1) << FRAC;

  typedef struct packed {
    q_t drive;
    q_t command;
  } cascade_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // [31:0] setpoint, [63:32] outer_measure, [95:64] inner_measure
  logic [3*IN_BITS-1:0]          s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  // [47:0] drive, [95:48] outer_command
  logic [2*OUT_BITS-1:0]         m_axis_tdata;
  logic                          cfg_we_i;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i;
  logic [LIMIT_BITS-1:0]         cfg_wdata_i;

  // shadow copy of the register file and loop state
  logic [GAIN_BITS-1:0]  gain_reg [NUM_GAINS];
  logic [LIMIT_BITS-1:0] lim_int_reg;
  logic [LIMIT_BITS-1:0] lim_out_reg;
  q_t                    prev_err [2];
  q_t                    integ [2];

  cascade_out_t expected_q[$];
  int           fail_count;
  // no idling on either side while set
  bit           steady;

  cascade_pid_controller_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic q_t sat_q(input wide_t v);
    if (v > Q_MAX) return q_t'(Q_MAX);
    if (v < Q_MIN) return q_t'(Q_MIN);
    return q_t'(v);
  endfunction

  // exact product, arithmetic shift (floor), then saturate
  function automatic q_t fx_scale(input q_t a, input logic [GAIN_BITS-1:0] g);
    wide_t wa, wg;
    wa = a;
    wg = $signed(g);
    return sat_q((wa * wg) >>> FRAC);
  endfunction

  function automatic q_t clamp_sym(input q_t v, input logic [LIMIT_BITS-1:0] lim);
    wide_t wv, wl;
    wv = v;
    wl = {1'b0, lim};
    if (wv > wl) return q_t'(wl);
    if (wv < -wl) return q_t'(-wl);
    return v;
  endfunction

  // one positional PID loop; k selects outer (0) or inner (1) state
  function automatic q_t loop_update(input bit k, input q_t target, input q_t fb,
                                     input logic [GAIN_BITS-1:0] kp,
                                     input logic [GAIN_BITS-1:0] ki,
                                     input logic [GAIN_BITS-1:0] kd);
    q_t err, pterm, dterm, sum_out;
    err = sat_q(wide_t'(target) - wide_t'(fb));
    dterm = fx_scale(sat_q(wide_t'(err) - wide_t'(prev_err[k])), kd);
    pterm = fx_scale(err, kp);
    prev_err[k] = err;
    integ[k] = clamp_sym(sat_q(wide_t'(integ[k]) + wide_t'(fx_scale(err, ki))), lim_int_reg);
    sum_out = sat_q(wide_t'(sat_q(wide_t'(pterm) + wide_t'(dterm))) + wide_t'(integ[k]));
    return clamp_sym(sum_out, lim_out_reg);
  endfunction

  function automatic cascade_out_t cascade_step(input logic signed [IN_BITS-1:0] sp,
                                                input logic signed [IN_BITS-1:0] om,
                                                input logic signed [IN_BITS-1:0] im);
    cascade_out_t res;
    q_t s, o, i;
    s = sp;
    o = om;
    i = im;
    res.command = loop_update(1'b0, s, o, gain_reg[cpid_pkg::REG_OUTER_KP],
                              gain_reg[cpid_pkg::REG_OUTER_KI],
                              gain_reg[cpid_pkg::REG_OUTER_KD]);
    res.drive = loop_update(1'b1, res.command, i, gain_reg[cpid_pkg::REG_INNER_KP],
                            gain_reg[cpid_pkg::REG_INNER_KI],
                            gain_reg[cpid_pkg::REG_INNER_KD]);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_fail(input string msg);
    fail_count++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    cascade_out_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_fail($sformatf("output beat with nothing pending, data %h", m_axis_tdata));
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[OUT_BITS-1:0] !== want.drive)
          report_fail($sformatf("drive got %0d want %0d",
                                $signed(m_axis_tdata[OUT_BITS-1:0]), want.drive));
        if (m_axis_tdata[2*OUT_BITS-1:OUT_BITS] !== want.command)
          report_fail($sformatf("outer_command got %0d want %0d",
                                $signed(m_axis_tdata[2*OUT_BITS-1:OUT_BITS]), want.command));
      end
    end
  end

  // output side back-pressure, about a third of the cycles
  always @(negedge clk_i) m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [IN_BITS-1:0] sp, input logic [IN_BITS-1:0] om,
                             input logic [IN_BITS-1:0] im);
    // short random gaps, now and then a long one to land anywhere in the
    // block's compute window
    while (!steady && $urandom_range(0, 99) < 33) @(negedge clk_i);
    if (!steady && $urandom_range(0, 9) == 0) repeat ($urandom_range(1, 64)) @(negedge clk_i);
    @(negedge clk_i);
    s_axis_tdata  <= {im, om, sp};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    expected_q.push_back(cascade_step(sp, om, im));
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LIMIT_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cpid_pkg::REG_LIM_INT) lim_int_reg = value;
    else if (idx == cpid_pkg::REG_LIM_OUT) lim_out_reg = value;
    else gain_reg[idx] = value[GAIN_BITS-1:0];
  endtask

  // same gains on both loops; junk above the gain width must be dropped
  task automatic write_gains(input logic [GAIN_BITS-1:0] kp, input logic [GAIN_BITS-1:0] ki,
                             input logic [GAIN_BITS-1:0] kd);
    write_reg(cpid_pkg::REG_OUTER_KP, LIMIT_BITS'({$urandom, kp}));
    write_reg(cpid_pkg::REG_OUTER_KI, LIMIT_BITS'({$urandom, ki}));
    write_reg(cpid_pkg::REG_OUTER_KD, LIMIT_BITS'({$urandom, kd}));
    write_reg(cpid_pkg::REG_INNER_KP, LIMIT_BITS'({$urandom, kp}));
    write_reg(cpid_pkg::REG_INNER_KI, LIMIT_BITS'({$urandom, ki}));
    write_reg(cpid_pkg::REG_INNER_KD, LIMIT_BITS'({$urandom, kd}));
  endtask

  // every item gives one beat, so an empty queue means the block is idle
  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [IN_BITS-1:0] noise_field();
    case ($urandom_range(0, 7))
      0: return IN_MAX;
      1: return IN_MIN;
      2, 3: return IN_BITS'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return G_MAX;
      1: return G_MIN;
      2: return '0;
      3, 4, 5: return GAIN_BITS'(int'($urandom_range(0, 8 << FRAC)) - (4 << FRAC));
      default: return GAIN_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_BITS-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: return LIMIT_BITS'($urandom_range(0, 1000)) << FRAC;
      default: return LIMIT_BITS'({$urandom, $urandom});
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset gains: kp 1, ki 0, kd 3 / 5, limits 500 and 65535
  task automatic test_reset_defaults();
    send_sample('0, '0, '0);
    send_sample(IN_ONE, '0, '0);
    send_sample(IN_ONE, '0, '0);         // same outer error twice, its derivative drops out
    send_sample(IN_MAX, IN_MIN, '0);     // error beyond 32 bits, output clamps
    send_sample(IN_MIN, IN_MAX, IN_MAX);
    send_sample(IN_MIN, IN_MIN, IN_MIN);
    send_sample(IN_NLSB, IN_BITS'(1), '0); // negative products round toward -inf
    send_sample('0, '0, IN_MAX);
    wait_idle();
  endtask

  task automatic test_gain_extremes();
    // largest gains and limits: products hit the 48 bit saturation
    write_gains(G_MAX, G_MAX, G_MAX);
    write_reg(cpid_pkg::REG_LIM_INT, '1);
    write_reg(cpid_pkg::REG_LIM_OUT, '1);
    send_sample(IN_MAX, IN_MIN, IN_MIN);
    send_sample(IN_MIN, IN_MAX, IN_MAX);
    send_sample(IN_BITS'(1), '0, '0);
    send_sample('0, '0, '0);
    wait_idle();
    write_gains(G_MIN, G_MIN, G_MIN);
    send_sample(IN_MAX, IN_MIN, IN_MIN);
    send_sample(IN_MIN, IN_MAX, IN_MAX);
    send_sample(IN_NLSB, '0, '0);
    wait_idle();
  endtask

  task automatic test_zero_limits();
    write_gains(G_ONE << 1, G_ONE >> 1, G_ONE);
    write_reg(cpid_pkg::REG_LIM_INT, '0);
    write_reg(cpid_pkg::REG_LIM_OUT, '0);
    send_sample(IN_MAX, '0, '0);
    send_sample(IN_ONE, '0, IN_MIN);
    send_sample('0, '0, '0);
    wait_idle();
  endtask

  // Each setting runs tracking sequences: a held target with a steady
  // position offset winds the integrals up into their clamps; the rest is
  // full-range noise.
  task automatic test_random_settings();
    int target, offset, run_left;
    logic [IN_BITS-1:0] sp, om, im;
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < NUM_GAINS; r++)
        write_reg(CFG_IDX_BITS'(int'(cpid_pkg::REG_OUTER_KP) + r),
                  LIMIT_BITS'({$urandom, pick_gain()}));
      write_reg(cpid_pkg::REG_LIM_INT, pick_limit());
      write_reg(cpid_pkg::REG_LIM_OUT, pick_limit());
      run_left = 0;
      for (int n = 0; n < 250; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 40);
          target   = (int'($urandom_range(0, 2000)) - 1000) << 12;
          offset   = int'($urandom_range(0, 20 << FRAC)) - (10 << FRAC);
        end
        run_left--;
        if ($urandom_range(0, 99) < 70) begin
          sp = target;
          om = target - offset + int'($urandom_range(0, 255)) - 128;
          im = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        end else begin
          sp = noise_field();
          om = noise_field();
          im = noise_field();
        end
        send_sample(sp, om, im);
      end
      wait_idle();
    end
  endtask

  // back-to-back beats on both sides, with one full drain in the middle
  task automatic test_steady_stream();
    write_gains(G_ONE, G_ONE >> 5, GAIN_BITS'(G_ONE * 3));
    write_reg(cpid_pkg::REG_LIM_INT, LIMIT_BITS'(500) << FRAC);
    write_reg(cpid_pkg::REG_LIM_OUT, LIMIT_BITS'(1000) << FRAC);
    steady = 1'b1;
    for (int n = 0; n < 250; n++) begin
      if (n == 150) wait_idle();
      send_sample(IN_BITS'(int'($urandom_range(0, 40 << FRAC)) - (20 << FRAC)),
                  IN_BITS'(int'($urandom_range(0, 40 << FRAC)) - (20 << FRAC)),
                  IN_BITS'(int'($urandom_range(0, 1 << 20)) - (1 << 19)));
    end
    wait_idle();
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = cpid_pkg::REG_OUTER_KP;
    cfg_wdata_i   = '0;
    steady        = 1'b0;
    fail_count    = 0;
    gain_reg[cpid_pkg::REG_OUTER_KP] = cpid_pkg::OUTER_KP_RST;
    gain_reg[cpid_pkg::REG_OUTER_KI] = cpid_pkg::OUTER_KI_RST;
    gain_reg[cpid_pkg::REG_OUTER_KD] = cpid_pkg::OUTER_KD_RST;
    gain_reg[cpid_pkg::REG_INNER_KP] = cpid_pkg::INNER_KP_RST;
    gain_reg[cpid_pkg::REG_INNER_KI] = cpid_pkg::INNER_KI_RST;
    gain_reg[cpid_pkg::REG_INNER_KD] = cpid_pkg::INNER_KD_RST;
    lim_int_reg = cpid_pkg::LIM_INT_UNITS << FRAC;
    lim_out_reg = cpid_pkg::LIM_OUT_UNITS << FRAC;
    prev_err[0] = '0;
    prev_err[1] = '0;
    integ[0]    = '0;
    integ[1]    = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_gain_extremes();
    test_zero_limits();
    test_random_settings();
    test_steady_stream();

    wait_idle();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #12ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
